### rtl/plas_pkg.sv
// Shared types, constants and helpers for the profile local alignment scorer.
// No dependencies.
package plas_pkg;

  localparam int QUERY_MAX_DEF = 1024;
  localparam int DB_MAX_DEF    = 4096;
  localparam int ALPHABET_DEF  = 32;

  // Internal score width, signed.
  localparam int SW = 24;

  localparam logic [1:0] OP_PROF   = 2'd0;
  localparam logic [1:0] OP_RES    = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  localparam logic [1:0] REG_GAP_OPEN   = 2'd0;
  localparam logic [1:0] REG_GAP_EXTEND = 2'd1;
  localparam logic [1:0] REG_QUERY_LEN  = 2'd2;

  localparam logic [7:0]  GAP_OPEN_RST   = 8'd10;
  localparam logic [7:0]  GAP_EXTEND_RST = 8'd2;
  localparam logic [10:0] QUERY_LEN_RST  = 11'd1024;

  typedef enum logic [1:0] {
    K_PROF   = 2'd0,
    K_RES    = 2'd1,
    K_FINISH = 2'd2,
    K_NONE   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [9:0]  pos;
    logic [4:0]  col;
    logic [7:0]  score;
    logic [4:0]  residue;
  } item_t;

  typedef struct packed {
    logic [7:0]  gap_open;
    logic [7:0]  gap_extend;
    logic [10:0] query_length;
  } cfg_t;

  typedef struct packed {
    logic [16:0] score;
    logic [9:0]  start_query;
    logic [10:0] end_query;
    logic [11:0] start_db;
    logic [12:0] end_db;
    logic [12:0] db_length;
    logic        overflow;
  } res_t;

  function automatic logic signed [SW-1:0] smax(logic signed [SW-1:0] a,
                                                logic signed [SW-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

### rtl/plas_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
module plas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/plas_front.sv
// Input side: accepts and classifies items, keeps valid ones in a two-entry queue.
// Depends on plas_pkg.
module plas_front #(
  parameter int QUERY_MAX = plas_pkg::QUERY_MAX_DEF,
  parameter int ALPHABET  = plas_pkg::ALPHABET_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic [1:0]          opcode_i,
  input  logic [9:0]          prof_position_i,
  input  logic [4:0]          prof_residue_i,
  input  logic [7:0]          prof_score_i,
  input  logic [4:0]          residue_i,
  output logic                item_valid_o,
  output plas_pkg::item_t     item_o,
  input  logic                item_take_i
);

  plas_pkg::item_t buf_q [2];
  plas_pkg::item_t cls;
  logic            wr_q, rd_q;
  logic [1:0]      cnt_q;
  logic            acc, keep, take;

  always_comb begin
    cls.pos     = prof_position_i;
    cls.col     = prof_residue_i;
    cls.score   = prof_score_i;
    cls.residue = residue_i;
    unique case (opcode_i)
      plas_pkg::OP_PROF: begin
        if (int'(prof_position_i) < QUERY_MAX && int'(prof_residue_i) < ALPHABET) begin
          cls.kind = plas_pkg::K_PROF;
        end else begin
          cls.kind = plas_pkg::K_NONE;
        end
      end
      plas_pkg::OP_RES:    cls.kind = plas_pkg::K_RES;
      plas_pkg::OP_FINISH: cls.kind = plas_pkg::K_FINISH;
      default:             cls.kind = plas_pkg::K_NONE;
    endcase
  end

  assign full_o       = (cnt_q == 2'd2);
  assign acc          = push_i && !full_o;
  assign keep         = acc && (cls.kind != plas_pkg::K_NONE);
  assign item_valid_o = (cnt_q != 2'd0);
  assign take         = item_take_i && item_valid_o;
  assign item_o       = buf_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (keep) begin
      buf_q[wr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (keep) begin
        wr_q <= !wr_q;
      end
      if (take) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + 2'(keep) - 2'(take);
    end
  end

endmodule

### rtl/plas_core.sv
// Back end: profile store, forward row pass, backward start search and result register.
// Depends on plas_pkg and plas_ram.
module plas_core #(
  parameter int QUERY_MAX = plas_pkg::QUERY_MAX_DEF,
  parameter int DB_MAX    = plas_pkg::DB_MAX_DEF,
  parameter int ALPHABET  = plas_pkg::ALPHABET_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  plas_pkg::cfg_t  cfg_i,
  input  logic            item_valid_i,
  input  plas_pkg::item_t item_i,
  output logic            item_take_o,
  output plas_pkg::res_t  res_o,
  output logic            res_valid_o,
  input  logic            res_pop_i
);

  localparam int SW  = plas_pkg::SW;
  localparam int QW  = $clog2(QUERY_MAX);
  localparam int QCW = $clog2(QUERY_MAX + 1);
  localparam int DBW = $clog2(DB_MAX);
  localparam int DCW = $clog2(DB_MAX + 1);
  localparam int PD  = QUERY_MAX * ALPHABET;
  localparam int PAW = $clog2(PD);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CLR   = 9'b000000010,
    S_FRD   = 9'b000000100,
    S_FCALC = 9'b000001000,
    S_BINIT = 9'b000010000,
    S_BROW  = 9'b000100000,
    S_BRD   = 9'b001000000,
    S_BCALC = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [QW-1:0]  j_q, j_d, bq_q, bq_d, l_q, l_d;
  logic [DBW-1:0] i_q, i_d, bdb_q, bdb_d, k_q, k_d;
  logic [DCW-1:0] dbc_q, dbc_d;
  logic           ovf_q, ovf_d, pok_q, pok_d, outv_q, outv_d;
  logic [4:0]     res_q, res_d;
  logic signed [SW-1:0] h_q, h_d, p_q, p_d, f_q, f_d, cost_q, cost_d, best_q, best_d;
  plas_pkg::res_t out_q, out_d;

  logic           prof_we, row_we, db_we;
  logic [PAW-1:0] prof_waddr, prof_raddr;
  logic [7:0]     prof_rdata;
  logic [SW-1:0]  rowh_wdata, rowe_wdata, rowh_rdata, rowe_rdata;
  logic [4:0]     db_rdata, col;
  logic           col_ok;
  logic [QCW-1:0] used;

  logic signed [SW-1:0] qs, rs, qr, prof, rh, re;
  logic signed [SW-1:0] ffn, fen, fhn, bfn, ben, bhn;

  assign qs   = $signed({{(SW-8){1'b0}}, cfg_i.gap_open});
  assign rs   = $signed({{(SW-8){1'b0}}, cfg_i.gap_extend});
  assign qr   = qs + rs;
  assign rh   = $signed(rowh_rdata);
  assign re   = $signed(rowe_rdata);
  assign prof = pok_q ? $signed({{(SW-8){prof_rdata[7]}}, prof_rdata}) : '0;
  assign used = (int'(cfg_i.query_length) > QUERY_MAX) ? QCW'(QUERY_MAX)
                                                         : QCW'(cfg_i.query_length);

  assign col        = (state_q == S_BRD) ? db_rdata : res_q;
  assign col_ok     = int'(col) < ALPHABET;
  assign prof_raddr = PAW'(int'(j_q) * ALPHABET + (col_ok ? int'(col) : 0));
  assign prof_waddr = PAW'(int'(item_i.pos) * ALPHABET + int'(item_i.col));

  // Forward and backward cells.
  always_comb begin
    ffn = plas_pkg::smax(f_q - rs, h_q - qr);
    fen = plas_pkg::smax(re - rs, rh - qr);
    fhn = plas_pkg::smax(plas_pkg::smax(p_q + prof, '0), plas_pkg::smax(ffn, fen));
    bfn = plas_pkg::smax(f_q, h_q - qs) - rs;
    ben = plas_pkg::smax(re, rh - qs) - rs;
    bhn = plas_pkg::smax(plas_pkg::smax(ben, bfn), p_q + prof);
  end

  always_comb begin
    state_d    = state_q;
    j_d        = j_q;
    i_d        = i_q;
    bq_d       = bq_q;
    bdb_d      = bdb_q;
    k_d        = k_q;
    l_d        = l_q;
    dbc_d      = dbc_q;
    ovf_d      = ovf_q;
    res_d      = res_q;
    h_d        = h_q;
    p_d        = p_q;
    f_d        = f_q;
    cost_d     = cost_q;
    best_d     = best_q;
    out_d      = out_q;
    pok_d      = col_ok;
    item_take_o = 1'b0;
    prof_we    = 1'b0;
    db_we      = 1'b0;
    row_we     = 1'b0;
    rowh_wdata = '0;
    rowe_wdata = '0;
    outv_d     = outv_q && !res_pop_i;

    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          item_take_o = 1'b1;
          res_d       = item_i.residue;
          case (item_i.kind)
            plas_pkg::K_PROF: prof_we = 1'b1;
            plas_pkg::K_RES: begin
              if (int'(dbc_q) >= DB_MAX) begin
                ovf_d = 1'b1;
              end else begin
                db_we = 1'b1;
                j_d   = '0;
                h_d   = '0;
                p_d   = '0;
                f_d   = -qs;
                if (dbc_q == '0) begin
                  state_d = S_CLR;
                end else if (used == '0) begin
                  dbc_d = dbc_q + 1'b1;
                end else begin
                  state_d = S_FRD;
                end
              end
            end
            plas_pkg::K_FINISH: begin
              k_d    = '0;
              l_d    = '0;
              cost_d = '0;
              j_d    = '0;
              state_d = (best_q > 0) ? S_BINIT : S_DONE;
            end
            default: ;
          endcase
        end
      end
      S_CLR: begin
        row_we     = 1'b1;
        rowe_wdata = -qs;
        if (int'(j_q) == QUERY_MAX - 1) begin
          j_d = '0;
          if (used == '0) begin
            dbc_d   = dbc_q + 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_FRD;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_FRD: state_d = S_FCALC;
      S_FCALC: begin
        row_we     = 1'b1;
        rowh_wdata = fhn;
        rowe_wdata = fen;
        h_d        = fhn;
        f_d        = ffn;
        p_d        = rh;
        if (fhn > best_q) begin
          best_d = fhn;
          bdb_d  = DBW'(dbc_q);
          bq_d   = j_q;
        end
        if (QCW'(j_q) + 1'b1 == used) begin
          dbc_d   = dbc_q + 1'b1;
          state_d = S_IDLE;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_FRD;
        end
      end
      S_BINIT: begin
        row_we     = 1'b1;
        rowh_wdata = '1;
        rowe_wdata = '1;
        if (j_q == bq_q) begin
          i_d     = bdb_q;
          h_d     = '1;
          f_d     = '1;
          p_d     = '0;
          state_d = S_BROW;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_BROW: state_d = S_BRD;
      S_BRD:  state_d = S_BCALC;
      S_BCALC: begin
        row_we     = 1'b1;
        rowh_wdata = bhn;
        rowe_wdata = ben;
        h_d        = bhn;
        f_d        = bfn;
        p_d        = rh;
        if (bhn > cost_q) begin
          cost_d = bhn;
          k_d    = i_q;
          l_d    = j_q;
        end
        if (bhn > cost_q && bhn >= best_q) begin
          state_d = S_DONE;
        end else if (j_q == '0) begin
          if (i_q == '0) begin
            state_d = S_DONE;
          end else begin
            i_d     = i_q - 1'b1;
            j_d     = bq_q;
            h_d     = '1;
            f_d     = '1;
            p_d     = '1;
            state_d = S_BROW;
          end
        end else begin
          j_d     = j_q - 1'b1;
          state_d = S_BRD;
        end
      end
      S_DONE: begin
        if (!outv_q || res_pop_i) begin
          outv_d          = 1'b1;
          out_d.db_length = 13'(dbc_q);
          out_d.overflow  = ovf_q;
          if (best_q > 0) begin
            out_d.score       = 17'(best_q);
            out_d.start_query = 10'(l_q);
            out_d.end_query   = 11'(int'(bq_q) + 1);
            out_d.start_db    = 12'(k_q);
            out_d.end_db      = 13'(int'(bdb_q) + 1);
          end else begin
            out_d.score       = '0;
            out_d.start_query = '0;
            out_d.end_query   = '0;
            out_d.start_db    = '0;
            out_d.end_db      = '0;
          end
          best_d  = '0;
          bdb_d   = '0;
          bq_d    = '0;
          dbc_d   = '0;
          ovf_d   = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      j_q     <= '0;
      i_q     <= '0;
      bq_q    <= '0;
      bdb_q   <= '0;
      k_q     <= '0;
      l_q     <= '0;
      dbc_q   <= '0;
      ovf_q   <= 1'b0;
      best_q  <= '0;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
      i_q     <= i_d;
      bq_q    <= bq_d;
      bdb_q   <= bdb_d;
      k_q     <= k_d;
      l_q     <= l_d;
      dbc_q   <= dbc_d;
      ovf_q   <= ovf_d;
      best_q  <= best_d;
      outv_q  <= outv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    h_q    <= h_d;
    p_q    <= p_d;
    f_q    <= f_d;
    cost_q <= cost_d;
    pok_q  <= pok_d;
    out_q  <= out_d;
  end

  assign res_o       = out_q;
  assign res_valid_o = outv_q;

  plas_ram #(.WIDTH(8), .DEPTH(PD)) u_prof (
    .clk_i   (clk_i),
    .we_i    (prof_we),
    .waddr_i (prof_waddr),
    .wdata_i (item_i.score),
    .raddr_i (prof_raddr),
    .rdata_o (prof_rdata)
  );

  plas_ram #(.WIDTH(SW), .DEPTH(QUERY_MAX)) u_row_h (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (j_q),
    .wdata_i (rowh_wdata),
    .raddr_i (j_q),
    .rdata_o (rowh_rdata)
  );

  plas_ram #(.WIDTH(SW), .DEPTH(QUERY_MAX)) u_row_e (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (j_q),
    .wdata_i (rowe_wdata),
    .raddr_i (j_q),
    .rdata_o (rowe_rdata)
  );

  plas_ram #(.WIDTH(5), .DEPTH(DB_MAX)) u_db (
    .clk_i   (clk_i),
    .we_i    (db_we),
    .waddr_i (DBW'(dbc_q)),
    .wdata_i (item_i.residue),
    .raddr_i (i_q),
    .rdata_o (db_rdata)
  );

endmodule

### rtl/profile_local_alignment_score.sv
// Top level of the profile local alignment scorer: configuration registers,
// front queue and back end. Depends on plas_pkg, plas_front and plas_core.
//
// Local alignment with affine gaps of a loaded query profile against a streamed
// database sequence. The first residue of a sequence first sweeps all QUERY_MAX
// entries of both row memories, then every residue passes over the used query
// cells, each cell a read and a compute step on the row memories. A finish item
// presets the rows up to bq, the end query position, then runs the backward
// search, a row step and then a read and a compute step per cell, bounded by
// the end cell, and loads the result register. A two-entry input queue and the
// result register let both sides stall freely.
module profile_local_alignment_score #(
  parameter int QUERY_MAX = plas_pkg::QUERY_MAX_DEF,
  parameter int DB_MAX    = plas_pkg::DB_MAX_DEF,
  parameter int ALPHABET  = plas_pkg::ALPHABET_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode_i,
  input  logic [9:0]  prof_position_i,
  input  logic [4:0]  prof_residue_i,
  input  logic [7:0]  prof_score_i,
  input  logic [4:0]  residue_i,
  output logic        empty,
  input  logic        pop,
  output logic [16:0] score_o,
  output logic [9:0]  start_query_o,
  output logic [10:0] end_query_o,
  output logic [11:0] start_db_o,
  output logic [12:0] end_db_o,
  output logic [12:0] db_length_o,
  output logic        overflow_o
);

  plas_pkg::cfg_t  cfg_q;
  plas_pkg::item_t item;
  plas_pkg::res_t  res;
  logic            item_valid, item_take, res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gap_open     <= plas_pkg::GAP_OPEN_RST;
      cfg_q.gap_extend   <= plas_pkg::GAP_EXTEND_RST;
      cfg_q.query_length <= plas_pkg::QUERY_LEN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        plas_pkg::REG_GAP_OPEN:   cfg_q.gap_open     <= cfg_wdata_i[7:0];
        plas_pkg::REG_GAP_EXTEND: cfg_q.gap_extend   <= cfg_wdata_i[7:0];
        plas_pkg::REG_QUERY_LEN:  cfg_q.query_length <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  plas_front #(.QUERY_MAX(QUERY_MAX), .ALPHABET(ALPHABET)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_o          (full),
    .opcode_i        (opcode_i),
    .prof_position_i (prof_position_i),
    .prof_residue_i  (prof_residue_i),
    .prof_score_i    (prof_score_i),
    .residue_i       (residue_i),
    .item_valid_o    (item_valid),
    .item_o          (item),
    .item_take_i     (item_take)
  );

  plas_core #(.QUERY_MAX(QUERY_MAX), .DB_MAX(DB_MAX), .ALPHABET(ALPHABET)) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .res_o        (res),
    .res_valid_o  (res_valid),
    .res_pop_i    (pop)
  );

  assign empty         = !res_valid;
  assign score_o       = res.score;
  assign start_query_o = res.start_query;
  assign end_query_o   = res.end_query;
  assign start_db_o    = res.start_db;
  assign end_db_o      = res.end_db;
  assign db_length_o   = res.db_length;
  assign overflow_o    = res.overflow;

endmodule

### sim/tb_profile_local_alignment_score.sv
// Self-checking testbench for profile_local_alignment_score: profile loads,
// residue streams and finish beats checked against a built-in score predictor.
// Depends on plas_pkg and the RTL top level.
`timescale 1ns / 100ps

module tb_profile_local_alignment_score;

  class align_scoreboard;
    byte  prof_tab[32768];
    int   h_row[1024];
    int   e_row[1024];
    bit [4:0] db_res[4096];
    int   best, best_db, best_q, db_cnt;
    bit   ovf;
    int   gopen, gext, qlen;
    plas_pkg::res_t pending[$];
    int   errors;

    function new();
      gopen = int'(plas_pkg::GAP_OPEN_RST);
      gext  = int'(plas_pkg::GAP_EXTEND_RST);
      qlen  = int'(plas_pkg::QUERY_LEN_RST);
      foreach (h_row[j]) begin
        h_row[j] = 0;
        e_row[j] = -gopen;
      end
    endfunction

    function void write_reg(logic [1:0] idx, int val);
      case (idx)
        plas_pkg::REG_GAP_OPEN:   gopen = val & 'hFF;
        plas_pkg::REG_GAP_EXTEND: gext  = val & 'hFF;
        plas_pkg::REG_QUERY_LEN:  qlen  = val & 'h7FF;
        default: ;
      endcase
    endfunction

    function int psc(int j, int r);
      return int'(prof_tab[j * 32 + r]);
    endfunction

    function void forward_row(int r);
      int h, p, f, e, t, n, qr;
      qr = gopen + gext;
      h = 0; p = 0; f = -gopen;
      n = (qlen > 1024) ? 1024 : qlen;
      for (int j = 0; j < n; j++) begin
        h -= qr;
        f -= gext;
        if (h > f) f = h;
        t = h_row[j] - qr;
        e = e_row[j] - gext;
        if (t > e) e = t;
        h = p + psc(j, r);
        if (h < 0) h = 0;
        if (h < f) h = f;
        if (h < e) h = e;
        p = h_row[j];
        h_row[j] = h;
        e_row[j] = e;
        if (h > best) begin
          best = h;
          best_db = db_cnt;
          best_q = j;
        end
      end
    endfunction

    function void find_start(output int sdb, output int sq);
      int cost, h, f, p, t;
      bit stop;
      cost = 0; sdb = 0; sq = 0; stop = 0;
      for (int j = 0; j <= best_q; j++) begin
        h_row[j] = -1;
        e_row[j] = -1;
      end
      for (int i = best_db; i >= 0 && !stop; i--) begin
        h = -1;
        f = -1;
        p = (i == best_db) ? 0 : -1;
        for (int j = best_q; j >= 0 && !stop; j--) begin
          f = ((f > h - gopen) ? f : h - gopen) - gext;
          t = h_row[j] - gopen;
          e_row[j] = ((e_row[j] > t) ? e_row[j] : t) - gext;
          h = (e_row[j] > f) ? e_row[j] : f;
          t = p + psc(j, int'(db_res[i]));
          if (t > h) h = t;
          p = h_row[j];
          h_row[j] = h;
          if (h > cost) begin
            cost = h;
            sdb = i;
            sq = j;
            if (cost >= best) stop = 1;
          end
        end
      end
    endfunction

    function void note(plas_pkg::item_t it);
      plas_pkg::res_t r;
      int sdb, sq;
      case (it.kind)
        plas_pkg::K_PROF: prof_tab[int'(it.pos) * 32 + int'(it.col)] = it.score;
        plas_pkg::K_RES: begin
          if (db_cnt >= 4096) begin
            ovf = 1;
          end else begin
            if (db_cnt == 0) begin
              foreach (h_row[j]) begin
                h_row[j] = 0;
                e_row[j] = -gopen;
              end
            end
            db_res[db_cnt] = it.residue;
            forward_row(int'(it.residue));
            db_cnt++;
          end
        end
        plas_pkg::K_FINISH: begin
          r = '0;
          if (best > 0) begin
            find_start(sdb, sq);
            r.score = 17'(best);
            r.start_query = 10'(sq);
            r.start_db = 12'(sdb);
            r.end_query = 11'(best_q + 1);
            r.end_db = 13'(best_db + 1);
          end
          r.db_length = 13'(db_cnt);
          r.overflow = ovf;
          pending.push_back(r);
          best = 0; best_db = 0; best_q = 0; db_cnt = 0; ovf = 0;
        end
        default: ;
      endcase
    endfunction

    function void cmp_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check(plas_pkg::res_t got);
      plas_pkg::res_t w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat, actual %p", $time, got);
        errors++;
        return;
      end
      w = pending.pop_front();
      cmp_field("score", int'(w.score), int'(got.score));
      cmp_field("start_query", int'(w.start_query), int'(got.start_query));
      cmp_field("end_query", int'(w.end_query), int'(got.end_query));
      cmp_field("start_db", int'(w.start_db), int'(got.start_db));
      cmp_field("end_db", int'(w.end_db), int'(got.end_db));
      cmp_field("db_length", int'(w.db_length), int'(got.db_length));
      cmp_field("overflow", int'(w.overflow), int'(got.overflow));
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [10:0] cfg_wdata_i;
  logic        push, full, empty, pop;
  logic [1:0]  opcode_i;
  logic [9:0]  prof_position_i;
  logic [4:0]  prof_residue_i;
  logic [7:0]  prof_score_i;
  logic [4:0]  residue_i;
  plas_pkg::res_t res_w, res_s;
  logic        empty_s;
  int          send_idle, recv_idle;
  align_scoreboard sb;

  profile_local_alignment_score i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .push, .full, .opcode_i, .prof_position_i, .prof_residue_i, .prof_score_i,
    .residue_i, .empty, .pop,
    .score_o(res_w.score), .start_query_o(res_w.start_query),
    .end_query_o(res_w.end_query), .start_db_o(res_w.start_db),
    .end_db_o(res_w.end_db), .db_length_o(res_w.db_length),
    .overflow_o(res_w.overflow)
  );

  initial clk_i = 0;
  always #5 clk_i = ~clk_i;

  initial begin
    #100ms;
    $display("tb_profile_local_alignment_score: errors");
    $finish;
  end

  always @(negedge clk_i) begin
    empty_s = empty;
    res_s = res_w;
  end

  always @(posedge clk_i) begin
    if (pop && !empty_s) sb.check(res_s);
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send(plas_pkg::item_t it);
    logic f;
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    opcode_i <= it.kind;
    prof_position_i <= it.pos;
    prof_residue_i <= it.col;
    prof_score_i <= it.score;
    residue_i <= it.residue;
    do begin
      @(negedge clk_i);
      f = full;
      @(posedge clk_i);
    end while (f);
    sb.note(it);
  endtask

  function automatic plas_pkg::item_t mk(plas_pkg::kind_e k, int pos, int col, int sc, int rs);
    plas_pkg::item_t it;
    it.kind = k;
    it.pos = 10'(pos);
    it.col = 5'(col);
    it.score = 8'(sc);
    it.residue = 5'(rs);
    return it;
  endfunction

  function automatic plas_pkg::item_t rnd(plas_pkg::kind_e k);
    return mk(k, $urandom, $urandom, $urandom, $urandom);
  endfunction

  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (3300) @(posedge clk_i);
  endtask

  task automatic wr_reg(logic [1:0] idx, int val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= 11'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic run_seq(int n, int fixed_res);
    plas_pkg::item_t it;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(7) == 0 && fixed_res < 0)
        send(mk(plas_pkg::K_PROF, $urandom_range(31), $urandom, $urandom, $urandom));
      if ($urandom_range(39) == 0) send(rnd(plas_pkg::K_NONE));
      it = rnd(plas_pkg::K_RES);
      if (fixed_res >= 0) it.residue = 5'(fixed_res);
      send(it);
    end
    send(rnd(plas_pkg::K_FINISH));
  endtask

  initial begin
    int sc;
    sb = new();
    rst_ni = 0; cfg_we_i = 0; cfg_idx_i = plas_pkg::REG_GAP_OPEN; cfg_wdata_i = '0;
    push = 0; opcode_i = plas_pkg::OP_PROF; prof_position_i = '0; prof_residue_i = '0;
    prof_score_i = '0; residue_i = '0;
    send_idle = 38; recv_idle = 57;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    settle();

    for (int p = 0; p < 32; p++)
      for (int c = 0; c < 32; c++) begin
        sc = (p == 0 && c == 0) ? -128 : (p == 1 && c == 31) ? 127 : $urandom;
        send(mk(plas_pkg::K_PROF, p, c, sc, $urandom));
      end
    for (int p = 32; p < 1024; p++) send(mk(plas_pkg::K_PROF, p, 5, $urandom, $urandom));

    send(rnd(plas_pkg::K_FINISH));
    send(rnd(plas_pkg::K_NONE));
    run_seq(3, 5);
    settle();
    wr_reg(plas_pkg::REG_QUERY_LEN, 2047);
    run_seq(2, 5);
    settle();
    wr_reg(plas_pkg::REG_QUERY_LEN, 0);
    run_seq(3, -1);
    settle();
    wr_reg(plas_pkg::REG_QUERY_LEN, 8);
    wr_reg(plas_pkg::REG_GAP_OPEN, 0);
    wr_reg(plas_pkg::REG_GAP_EXTEND, 0);
    run_seq(4, 0);
    run_seq(4, 31);
    settle();
    wr_reg(plas_pkg::REG_GAP_OPEN, 255);
    wr_reg(plas_pkg::REG_GAP_EXTEND, 255);
    run_seq(6, -1);
    settle();
    wr_reg(plas_pkg::REG_QUERY_LEN, 1);
    send_idle = 0; recv_idle = 0;
    for (int i = 0; i < 4100; i++) send(rnd(plas_pkg::K_RES));
    send(rnd(plas_pkg::K_FINISH));

    for (int regime = 0; regime < 3; regime++) begin
      send_idle = (regime == 0) ? 38 : (regime == 1) ? 57 : 0;
      recv_idle = (regime == 0) ? 57 : (regime == 1) ? 38 : 0;
      for (int ph = 0; ph < 3; ph++) begin
        settle();
        wr_reg(plas_pkg::REG_GAP_OPEN, (ph == 0) ? 0 : (ph == 1) ? 255 : $urandom_range(1, 20));
        wr_reg(plas_pkg::REG_GAP_EXTEND, (ph == 2) ? 0 : $urandom_range(0, 12));
        wr_reg(plas_pkg::REG_QUERY_LEN, (ph == 1) ? 32 : $urandom_range(0, 32));
        for (int s = 0; s < 16; s++) run_seq($urandom_range(0, 24), -1);
      end
    end

    push <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (3300) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_profile_local_alignment_score: clean");
    end else begin
      $display("tb_profile_local_alignment_score: errors");
    end
    $finish;
  end

endmodule

### profile_local_alignment_score.f
rtl/plas_pkg.sv
rtl/plas_ram.sv
rtl/plas_front.sv
rtl/plas_core.sv
rtl/profile_local_alignment_score.sv
sim/tb_profile_local_alignment_score.sv
